>>> hdl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
// No dependencies; used by dq_ctrl, dq_datapath and the top level.
package dq_pkg;

  localparam int ValueW  = 32;
  localparam int ReqW    = 3;
  localparam int CountOW = 5;
  localparam int StatusW = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK       = 3'd4
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_UPDATE = 2'd1,
    S_READ   = 2'd2,
    S_LOAD   = 2'd3
  } state_e;

  typedef struct packed {
    logic load_req;
    logic do_update;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

endpackage

>>> hdl/dq_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module dq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  output logic [Width-1:0] rdata_a_o,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> hdl/dq_ctrl.sv
// Sequencing state machine for the double-ended queue.
// Depends on dq_pkg for the state, command and status types.
module dq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dq_pkg::stat_t stat_i,
  output dq_pkg::cmd_t  cmd_o
);

  dq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      dq_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = dq_pkg::S_UPDATE;
        end
      end
      dq_pkg::S_UPDATE: begin
        cmd_o.do_update = 1'b1;
        state_d         = dq_pkg::S_READ;
      end
      dq_pkg::S_READ: begin
        state_d = dq_pkg::S_LOAD;
      end
      dq_pkg::S_LOAD: begin
        // hold until the output register is free
        if (!stat_i.out_full) begin
          cmd_o.capture = 1'b1;
          state_d       = dq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/dq_datapath.sv
// Ring pointers, slot RAM and result register of the double-ended queue.
// Depends on dq_pkg and dq_ram.
module dq_datapath #(
  parameter int Depth = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dq_pkg::cmd_t                        cmd_i,
  output dq_pkg::stat_t                       stat_o,
  input  logic [dq_pkg::ReqW-1:0]             req_type_i,
  input  logic signed [dq_pkg::ValueW-1:0]    push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dq_pkg::ValueW-1:0]    front_value_o,
  output logic signed [dq_pkg::ValueW-1:0]    back_value_o,
  output logic [dq_pkg::CountOW-1:0]          item_count_o,
  output logic                                is_empty_o,
  output logic [dq_pkg::StatusW-1:0]          status_o
);

  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [AddrW:0] DepthS = (AddrW + 1)'(Depth);

  logic [AddrW-1:0]                head_q, head_d;
  logic [CntW-1:0]                 count_q, count_d;
  logic [dq_pkg::ReqW-1:0]         req_q;
  logic signed [dq_pkg::ValueW-1:0] val_q;
  dq_pkg::status_e                 status_q, status_d;
  logic                            out_valid_q;

  logic full, empty;
  logic [CntW-1:0]  off_last;
  logic [AddrW:0]   tail_sum, last_sum, next_sum;
  logic [AddrW-1:0] tail_idx, last_idx, next_idx, head_dec;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [dq_pkg::ValueW-1:0] rdata_a, rdata_b;

  assign full     = (count_q == CntW'(Depth));
  assign empty    = (count_q == '0);
  assign off_last = empty ? '0 : count_q - 1'b1;

  // ring offsets from the head, wrapped by one conditional subtract
  assign tail_sum = {1'b0, head_q} + (AddrW + 1)'(count_q);
  assign last_sum = {1'b0, head_q} + (AddrW + 1)'(off_last);
  assign next_sum = {1'b0, head_q} + (AddrW + 1)'(1);
  assign tail_idx = (tail_sum >= DepthS) ? AddrW'(tail_sum - DepthS) : AddrW'(tail_sum);
  assign last_idx = (last_sum >= DepthS) ? AddrW'(last_sum - DepthS) : AddrW'(last_sum);
  assign next_idx = (next_sum >= DepthS) ? AddrW'(next_sum - DepthS) : AddrW'(next_sum);
  assign head_dec = (head_q == '0) ? AddrW'(Depth - 1) : head_q - 1'b1;

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = dq_pkg::ST_OK;
    we       = 1'b0;
    waddr    = tail_idx;
    case (dq_pkg::req_e'(req_q))
      dq_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          status_d = dq_pkg::ST_OVERFLOW;
        end else begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      dq_pkg::REQ_PUSH_FRONT: begin
        waddr = head_dec;
        if (full) begin
          status_d = dq_pkg::ST_OVERFLOW;
        end else begin
          we      = 1'b1;
          head_d  = head_dec;
          count_d = count_q + 1'b1;
        end
      end
      dq_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          status_d = dq_pkg::ST_UNDERFLOW;
        end else begin
          head_d  = next_idx;
          count_d = count_q - 1'b1;
        end
      end
      dq_pkg::REQ_POP_BACK: begin
        if (empty) begin
          status_d = dq_pkg::ST_UNDERFLOW;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.do_update) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      if (cmd_i.capture) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_type_i;
      val_q <= push_value_i;
    end
    if (cmd_i.do_update) begin
      status_q <= status_d;
    end
    if (cmd_i.capture) begin
      front_value_o <= empty ? -32'sd1 : $signed(rdata_a);
      back_value_o  <= empty ? -32'sd1 : $signed(rdata_b);
      item_count_o  <= dq_pkg::CountOW'(count_q);
      is_empty_o    <= empty;
      status_o      <= status_q;
    end
  end

  dq_ram #(
    .Width(dq_pkg::ValueW),
    .Depth(Depth)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we && cmd_i.do_update),
    .waddr_i  (waddr),
    .wdata_i  (val_q),
    .raddr_a_i(head_q),
    .rdata_a_o(rdata_a),
    .raddr_b_i(last_idx),
    .rdata_b_o(rdata_b)
  );

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_full = out_valid_q && out_stall_i;

endmodule

>>> hdl/double_ended_queue_top.sv
// Each request steps through accept, pointer update and slot write, RAM
// read and result capture; no new request is taken until its result is
// captured, and capture waits while the output is stalled. The sequence is
// set by the single-port write and the registered read of the slot RAM.
// Reset (rst_ni low, asynchronous): clears head, count, sequencer and output
// valid; slot contents stay undefined until pushed.
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dq_pkg::ReqW-1:0]          req_type_i,
  input  logic signed [dq_pkg::ValueW-1:0] push_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [dq_pkg::ValueW-1:0] front_value_o,
  output logic signed [dq_pkg::ValueW-1:0] back_value_o,
  output logic [dq_pkg::CountOW-1:0]       item_count_o,
  output logic                             is_empty_o,
  output logic [dq_pkg::StatusW-1:0]       status_o
);

  dq_pkg::cmd_t  cmd;
  dq_pkg::stat_t stat;

  // Sequencer: takes one request transfer, then steps the datapath through
  // update, read and capture. Capture waits while the previous result is
  // still stalled at the output, so no result is overwritten.
  dq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Datapath: ring head and count, slot RAM, and the result register that
  // decouples the output side from the next request.
  dq_datapath #(
    .Depth(DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_type_i   (req_type_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .front_value_o(front_value_o),
    .back_value_o (back_value_o),
    .item_count_o (item_count_o),
    .is_empty_o   (is_empty_o),
    .status_o     (status_o)
  );

`ifndef SYNTHESIS
  // a request transfer keeps the input side busy during its update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted during request processing");

  // an empty queue reads -1 at both ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (front_value_o == -32'sd1 && back_value_o == -32'sd1))
    else $error("empty queue does not read -1");

  // underflow only leaves an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == dq_pkg::ST_UNDERFLOW) |-> is_empty_o)
    else $error("underflow with stored values");

  // overflow only happens on a full, hence non-empty, queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == dq_pkg::ST_OVERFLOW) |-> !is_empty_o)
    else $error("overflow on an empty queue");
`endif

endmodule
